### rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the UTF-8 to UTF-16 decoder. The
// checks fall away when SYNTH is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/u8u16_pkg.sv
// ============================================================================
// UTF-8 to UTF-16 decoder package
// Byte masks, surrogate bases, queue sizing and the types shared between
// the decoder step and the top level.
// ============================================================================
package u8u16_pkg;

   // Byte classification masks and patterns.
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;

   // Code point handling.
   localparam logic [20:0] SUPP_BASE = 21'h010000;
   localparam logic [15:0] HI_SURR   = 16'hD800;
   localparam logic [15:0] LO_SURR   = 16'hDC00;

   // Result queue sizing: room for the two units of one byte plus slack.
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Outcome of decoding one byte against the current sequence state.
   typedef struct packed {
      logic [1:0]  n_units;
      logic [15:0] unit0;
      logic        last0;
      logic [15:0] unit1;
      logic [20:0] acc_next;
      logic [1:0]  rem_next;
   } step_type;

   // One queued result.
   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_last;
   } entry_type;

endpackage

### rtl/u8u16_if.sv
// ============================================================================
// UTF-8 to UTF-16 decoder channels
// Valid/ready channels for the byte requests and the code unit results.
// ============================================================================
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        is_last;

   modport source (output valid, output code_unit, output is_last, input ready);
   modport sink   (input valid, input code_unit, input is_last, output ready);
endinterface

### rtl/u8u16_step.sv
// ============================================================================
// UTF-8 decoder step
// Decodes one byte against the open sequence state and yields up to two
// UTF-16 code units together with the next sequence state.
// ============================================================================
module u8u16_step (
   input  logic [7:0]          in_byte,
   input  logic [20:0]         acc,
   input  logic [1:0]          rem,
   output u8u16_pkg::step_type step
);
   import u8u16_pkg::*;

   logic [20:0] acc_shift;
   logic [20:0] cp_off;
   logic        is_cont;
   logic        fresh_emit;
   logic [15:0] fresh_unit;

   // Continuation payload appended, and the offset form for surrogates.
   assign acc_shift  = {acc[14:0], in_byte[5:0]};
   assign cp_off     = acc_shift - SUPP_BASE;
   assign is_cont    = (in_byte & CONT_MASK) == CONT_CODE;
   assign fresh_emit = ~in_byte[7];
   assign fresh_unit = {8'h00, in_byte};

   // Byte decode.
   always_comb begin
      step          = '0;
      step.acc_next = acc;
      step.rem_next = rem;
      if (in_byte == 8'h00) begin
         // Terminator: drop any partial value.
         step.n_units  = 2'd1;
         step.unit0    = 16'h0000;
         step.last0    = 1'b1;
         step.acc_next = '0;
         step.rem_next = '0;
      end else if (rem != 2'd0 && is_cont) begin
         step.rem_next = rem - 2'd1;
         if (rem == 2'd1) begin
            // Sequence complete: one unit or a surrogate pair.
            step.acc_next = '0;
            if (acc_shift[20:16] == 5'd0) begin
               step.n_units = 2'd1;
               step.unit0   = acc_shift[15:0];
            end else begin
               step.n_units = 2'd2;
               step.unit0   = HI_SURR | {6'd0, cp_off[19:10]};
               step.unit1   = LO_SURR | {6'd0, cp_off[9:0]};
            end
         end else begin
            step.acc_next = acc_shift;
         end
      end else begin
         // A broken sequence first flushes its partial value.
         if (rem != 2'd0) begin
            step.unit0    = acc[15:0];
            step.acc_next = '0;
            step.rem_next = '0;
            if (fresh_emit) begin
               step.n_units = 2'd2;
               step.unit1   = fresh_unit;
            end else begin
               step.n_units = 2'd1;
            end
         end else if (fresh_emit) begin
            step.n_units = 2'd1;
            step.unit0   = fresh_unit;
         end
         // Lead bytes open a new sequence; stray continuations do nothing.
         if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
            step.acc_next = {18'd0, in_byte[2:0]};
            step.rem_next = 2'd3;
         end else if (in_byte[7:5] == 3'b111) begin
            step.acc_next = {17'd0, in_byte[3:0]};
            step.rem_next = 2'd2;
         end else if (in_byte[7:5] == 3'b110) begin
            step.acc_next = {16'd0, in_byte[4:0]};
            step.rem_next = 2'd1;
         end
      end
   end

endmodule

### rtl/utf8_to_utf16_decoder.sv
// ============================================================================
// UTF-8 to UTF-16 decoder
// Streaming converter from UTF-8 bytes to UTF-16 code units.
// ============================================================================
// One byte request is accepted per clock cycle unless the held byte is stalled.
// A byte is held in an input register, decoded from there and its results
// (none, one or two code units) are written into a four-entry result queue once
// it has room for two units; one unit leaves per cycle while the receiver is
// ready. Requests keep coming one byte a cycle while the result side drains and
// no byte fills two entries (a surrogate pair, or a flushed partial value with an
// ASCII byte). A zero byte produces a terminator unit flagged is_last.
module utf8_to_utf16_decoder (
   input logic        clock,
   input logic        reset,
   u8u16_req_if.sink  req_ch,
   u8u16_rsp_if.source rsp_ch
);
   import u8u16_pkg::*;
   `include "assert_macros.svh"

   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_byte_ff,  s1_byte_in;
   logic [20:0]      acc_ff,      acc_in;
   logic [1:0]       rem_ff,      rem_in;
   logic [QPTR_W-1:0] wr_ptr_ff,  wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff,  rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,   count_in;
   entry_type        queue_ff [QDEPTH];

   logic             req_accept;
   logic             advance;
   logic             pop;
   logic [1:0]       push_n;
   step_type         step;

   // Decode of the registered byte.
   u8u16_step u_step (
      .in_byte (s1_byte_ff),
      .acc     (acc_ff),
      .rem     (rem_ff),
      .step    (step)
   );

   // The held byte moves on once the queue has room for two units.
   assign advance    = s1_valid_ff && (count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign push_n     = advance ? step.n_units : 2'd0;
   assign pop        = rsp_ch.valid && rsp_ch.ready;

   // Result channel reads the queue head.
   assign rsp_ch.valid     = count_ff != '0;
   assign rsp_ch.code_unit = queue_ff[rd_ptr_ff].code_unit;
   assign rsp_ch.is_last   = queue_ff[rd_ptr_ff].is_last;

   // Next-state logic for the input register, sequence state and queue.
   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_byte_in  = req_accept ? req_ch.in_byte : s1_byte_ff;
      acc_in      = advance ? step.acc_next : acc_ff;
      rem_in      = advance ? step.rem_next : rem_ff;
      wr_ptr_in   = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in   = rd_ptr_ff + QPTR_W'(pop);
      count_in    = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   // Control and sequence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
         rem_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
         rem_ff      <= rem_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // Payload registers: input byte and queue entries.
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= '{code_unit: step.unit0, is_last: step.last0};
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= '{code_unit: step.unit1, is_last: 1'b0};
      end
   end

   // Checks on the queue accounting and the sequence state.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QDEPTH))
   `ASSERT_IMPLY(a_room_on_advance, clock, reset, advance, count_ff <= QCNT_W'(QDEPTH - 2))
   `ASSERT_NEXT(a_nul_clears, clock, reset, advance && s1_byte_ff == 8'h00, acc_ff == '0 && rem_ff == '0)
   `ASSERT_IMPLY(a_single_when_idle, clock, reset, s1_valid_ff && rem_ff == 2'd0, step.n_units <= 2'd1)
   `ASSERT_IMPLY(a_last_only_on_zero, clock, reset, rsp_ch.valid && rsp_ch.is_last, rsp_ch.code_unit == 16'h0000)

endmodule
